// ----- hw/rtl/ogru_pkg.sv -----
// ----------------------------------------------------------------------------
// ogru_pkg
// Shared types and constants of the occupancy grid ray update block.
// ----------------------------------------------------------------------------
package ogru_pkg;

	localparam int GRID_SIDE_DEF   = 256;
	localparam int ORIGIN_CELL_DEF = 128;
	localparam int CELL_BITS_DEF   = 16;

	localparam int POS_W     = 10;	// grid coordinate, covers origin and targets
	localparam int ERR_W     = 13;	// Bresenham error term
	localparam int CNT_W     = 9;
	localparam int VAL_W     = 16;
	localparam int COORD_IN_W = 8;
	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 3;
	localparam int STEP_W    = 17;	// signed step added to a cell
	localparam int SUM_W     = 34;	// cell plus step, before clamping

	localparam logic [CFG_W-1:0] LOG_FLOOR_RST    = 16'hFB00;	// -1280
	localparam logic [14:0]      LOG_CEILING_RST  = 15'd1280;
	localparam logic [CFG_W-1:0] FREE_STEP_RST    = 16'hFF9A;	// -102
	localparam logic [14:0]      HIT_STEP_RST     = 15'd218;
	localparam logic [CFG_W-1:0] DECAY_FACTOR_RST = 16'd62259;

	typedef enum logic [1:0] {
		CMD_DECAY = 2'd0,
		CMD_RAY   = 2'd1,
		CMD_READ  = 2'd2,
		CMD_NONE  = 2'd3
	} cmd_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LOG_FLOOR    = 3'd0,
		REG_LOG_CEILING  = 3'd1,
		REG_FREE_STEP    = 3'd2,
		REG_HIT_STEP     = 3'd3,
		REG_DECAY_FACTOR = 3'd4
	} cfg_reg_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_RAY_INIT,
		ST_RAY_VISIT,
		ST_RAY_SUM,
		ST_RAY_WR,
		ST_DEC_RD,
		ST_DEC_ABS,
		ST_DEC_MUL,
		ST_DEC_WR,
		ST_RD_ADDR,
		ST_RD_WAIT,
		ST_DONE
	} state_t;

endpackage

// ----- hw/rtl/occupancy_grid_ray_update.sv -----
// ----------------------------------------------------------------------------
// occupancy_grid_ray_update
// Log-odds occupancy grid: Bresenham ray update, decay sweep and cell read,
// all through one grid memory port under a small sequencer.
// ----------------------------------------------------------------------------
//  channel | signals                                   | beat
//  --------+-------------------------------------------+-----------------------
//  cmd     | cmd_valid cmd_ready command target_col    | one command
//          | target_row mark_hit                       |
//  rsp     | rsp_valid rsp_ready cell_value            | one result per command
//          | cells_touched                             |
//  cfg     | cfg_we cfg_index cfg_data                 | one register write
//
//  Ray: a skipped cell passes ST_RAY_VISIT alone; an updated cell goes through
//  ST_RAY_VISIT, ST_RAY_SUM and ST_RAY_WR, a grid RAM read-modify-write.
//  Decay reads, scales and writes back all GRID_SIDE*GRID_SIDE cells. Reset
//  starts a clearing pass over every cell with cmd_ready low. A command is taken
//  while a result waits; the next result then holds until rsp is taken.
// ----------------------------------------------------------------------------
module occupancy_grid_ray_update #(
	parameter int GRID_SIDE   = ogru_pkg::GRID_SIDE_DEF,
	parameter int ORIGIN_CELL = ogru_pkg::ORIGIN_CELL_DEF,
	parameter int CELL_BITS   = ogru_pkg::CELL_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,

	input  logic                               cmd_valid,
	output logic                               cmd_ready,
	input  logic [1:0]                         command,
	input  logic [ogru_pkg::COORD_IN_W-1:0]    target_col,
	input  logic [ogru_pkg::COORD_IN_W-1:0]    target_row,
	input  logic                               mark_hit,

	output logic                               rsp_valid,
	input  logic                               rsp_ready,
	output logic signed [ogru_pkg::VAL_W-1:0]  cell_value,
	output logic [ogru_pkg::CNT_W-1:0]         cells_touched,

	input  logic                               cfg_we,
	input  logic [ogru_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [ogru_pkg::CFG_W-1:0]         cfg_data
);

	localparam int DEPTH  = GRID_SIDE * GRID_SIDE;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int POS_W  = ogru_pkg::POS_W;
	localparam int ERR_W  = ogru_pkg::ERR_W;
	localparam int SUM_W  = ogru_pkg::SUM_W;
	localparam int CNT_W  = ogru_pkg::CNT_W;
	localparam int VAL_W  = ogru_pkg::VAL_W;
	localparam int PROD_W = CELL_BITS + 16;

	localparam logic [POS_W-1:0]  ORIGIN   = POS_W'(ORIGIN_CELL);
	localparam logic [POS_W:0]    SIDE_LIM = (POS_W + 1)'(GRID_SIDE);
	localparam logic [ADDR_W-1:0] SIDE_A   = ADDR_W'(GRID_SIDE);
	localparam logic [ADDR_W-1:0] LAST_A   = ADDR_W'(DEPTH - 1);
	localparam logic signed [SUM_W-1:0] CELL_MAX = SUM_W'((64'(1) << (CELL_BITS - 1)) - 64'(1));
	localparam logic signed [SUM_W-1:0] CELL_MIN = -CELL_MAX - SUM_W'(1);
	localparam logic [CNT_W-1:0]  CNT_SAT  = '1;

	// configuration
	logic signed [15:0] log_floor_q;
	logic [14:0]        log_ceiling_q;
	logic signed [15:0] free_step_q;
	logic [14:0]        hit_step_q;
	logic [15:0]        decay_factor_q;

	// control
	ogru_pkg::state_t state_q, state_d;
	logic [ADDR_W-1:0] sweep_q;
	logic              rsp_valid_q;

	// datapath
	logic [ogru_pkg::COORD_IN_W-1:0] tcol_q, trow_q;
	logic                mark_q;
	logic [POS_W-1:0]    pos_c_q, pos_r_q;
	logic [POS_W-1:0]    dc_q, dr_q;
	logic                sc_q, sr_q;
	logic signed [ERR_W-1:0] err_q;
	logic                last_q;
	logic signed [ogru_pkg::STEP_W-1:0] delta_q;
	logic signed [SUM_W-1:0] sum_q;
	logic [CNT_W-1:0]    count_q;
	logic [VAL_W-1:0]    res_val_q;
	logic                dneg_q;
	logic [CELL_BITS-1:0] dabs_q;
	logic [PROD_W-1:0]   prod_q;
	logic signed [VAL_W-1:0] cell_value_q;
	logic [CNT_W-1:0]    cells_touched_q;

	// grid memory
	logic [CELL_BITS-1:0] mem [DEPTH];
	logic [CELL_BITS-1:0] rdata_q;
	logic                 mem_we, mem_re;
	logic [ADDR_W-1:0]    mem_addr;
	logic [CELL_BITS-1:0] mem_wdata;

	// sequencer strobes
	logic adv, load_rsp, cmd_ready_c;

	// combinational datapath
	logic [POS_W-1:0]  end_c, end_r;
	logic              at_end, at_origin, pos_in, tgt_in, upd, sweep_last;
	logic [ADDR_W-1:0] pos_addr, tgt_addr;
	logic signed [ERR_W:0]   e2, dc_s, dr_s;
	logic                    step_c, step_r;
	logic signed [ERR_W-1:0] err_next;
	logic signed [SUM_W-1:0] clamp_v;
	logic [CELL_BITS-1:0]    dq, decay_val;
	logic [32:0]             rd_ext;

	assign end_c      = POS_W'(tcol_q);
	assign end_r      = POS_W'(trow_q);
	assign at_end     = (pos_c_q == end_c) && (pos_r_q == end_r);
	assign at_origin  = (pos_c_q == ORIGIN) && (pos_r_q == ORIGIN);
	assign pos_in     = ({1'b0, pos_c_q} < SIDE_LIM) && ({1'b0, pos_r_q} < SIDE_LIM);
	assign tgt_in     = ({1'b0, end_c} < SIDE_LIM) && ({1'b0, end_r} < SIDE_LIM);
	assign upd        = pos_in && (at_end ? mark_q : !at_origin);
	assign sweep_last = (sweep_q == LAST_A);
	assign pos_addr   = ADDR_W'(pos_r_q) * SIDE_A + ADDR_W'(pos_c_q);
	assign tgt_addr   = ADDR_W'(trow_q) * SIDE_A + ADDR_W'(tcol_q);

	assign e2       = {err_q, 1'b0};
	assign dc_s     = $signed((ERR_W + 1)'(dc_q));
	assign dr_s     = $signed((ERR_W + 1)'(dr_q));
	assign step_c   = e2 > -dr_s;
	assign step_r   = e2 < dc_s;
	assign err_next = err_q - (step_c ? ERR_W'(dr_s) : '0) + (step_r ? ERR_W'(dc_s) : '0);

	always_comb begin
		clamp_v = sum_q;
		if (clamp_v < SUM_W'(log_floor_q)) clamp_v = SUM_W'(log_floor_q);
		if (clamp_v > SUM_W'($signed({1'b0, log_ceiling_q}))) begin
			clamp_v = SUM_W'($signed({1'b0, log_ceiling_q}));
		end
		if (clamp_v < CELL_MIN) clamp_v = CELL_MIN;
		if (clamp_v > CELL_MAX) clamp_v = CELL_MAX;
	end

	assign dq        = prod_q[PROD_W-1:16];
	assign decay_val = dneg_q ? -dq : dq;
	assign rd_ext    = {{(33 - CELL_BITS){rdata_q[CELL_BITS-1]}}, rdata_q};

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ogru_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		cmd_ready_c = 1'b0;
		mem_we      = 1'b0;
		mem_re      = 1'b0;
		mem_addr    = sweep_q;
		mem_wdata   = '0;
		adv         = 1'b0;
		load_rsp    = 1'b0;
		case (state_q)
			ogru_pkg::ST_CLEAR: begin
				mem_we = 1'b1;
				if (sweep_last) state_d = ogru_pkg::ST_IDLE;
			end
			ogru_pkg::ST_IDLE: begin
				cmd_ready_c = 1'b1;
				if (cmd_valid) begin
					case (ogru_pkg::cmd_t'(command))
						ogru_pkg::CMD_DECAY: state_d = ogru_pkg::ST_DEC_RD;
						ogru_pkg::CMD_RAY:   state_d = ogru_pkg::ST_RAY_INIT;
						ogru_pkg::CMD_READ:  state_d = ogru_pkg::ST_RD_ADDR;
						default:             state_d = ogru_pkg::ST_DONE;
					endcase
				end
			end
			ogru_pkg::ST_RAY_INIT: state_d = ogru_pkg::ST_RAY_VISIT;
			ogru_pkg::ST_RAY_VISIT: begin
				mem_addr = pos_addr;
				if (upd) begin
					mem_re  = 1'b1;
					state_d = ogru_pkg::ST_RAY_SUM;
				end else if (at_end) begin
					state_d = ogru_pkg::ST_DONE;
				end else begin
					adv = 1'b1;
				end
			end
			ogru_pkg::ST_RAY_SUM: state_d = ogru_pkg::ST_RAY_WR;
			ogru_pkg::ST_RAY_WR: begin
				mem_we    = 1'b1;
				mem_addr  = pos_addr;
				mem_wdata = clamp_v[CELL_BITS-1:0];
				if (last_q) begin
					state_d = ogru_pkg::ST_DONE;
				end else begin
					adv     = 1'b1;
					state_d = ogru_pkg::ST_RAY_VISIT;
				end
			end
			ogru_pkg::ST_DEC_RD: begin
				mem_re  = 1'b1;
				state_d = ogru_pkg::ST_DEC_ABS;
			end
			ogru_pkg::ST_DEC_ABS: state_d = ogru_pkg::ST_DEC_MUL;
			ogru_pkg::ST_DEC_MUL: state_d = ogru_pkg::ST_DEC_WR;
			ogru_pkg::ST_DEC_WR: begin
				mem_we    = 1'b1;
				mem_wdata = decay_val;
				state_d   = sweep_last ? ogru_pkg::ST_DONE : ogru_pkg::ST_DEC_RD;
			end
			ogru_pkg::ST_RD_ADDR: begin
				mem_addr = tgt_addr;
				if (tgt_in) begin
					mem_re  = 1'b1;
					state_d = ogru_pkg::ST_RD_WAIT;
				end else begin
					state_d = ogru_pkg::ST_DONE;
				end
			end
			ogru_pkg::ST_RD_WAIT: state_d = ogru_pkg::ST_DONE;
			ogru_pkg::ST_DONE: begin
				if (!rsp_valid_q || rsp_ready) begin
					load_rsp = 1'b1;
					state_d  = ogru_pkg::ST_IDLE;
				end
			end
			default: state_d = ogru_pkg::ST_IDLE;
		endcase
	end

	// sweep counter for clearing pass and decay
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_q <= '0;
		end else if (state_q == ogru_pkg::ST_CLEAR || state_q == ogru_pkg::ST_DEC_WR) begin
			sweep_q <= sweep_last ? '0 : sweep_q + ADDR_W'(1);
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			log_floor_q    <= ogru_pkg::LOG_FLOOR_RST;
			log_ceiling_q  <= ogru_pkg::LOG_CEILING_RST;
			free_step_q    <= ogru_pkg::FREE_STEP_RST;
			hit_step_q     <= ogru_pkg::HIT_STEP_RST;
			decay_factor_q <= ogru_pkg::DECAY_FACTOR_RST;
		end else if (cfg_we) begin
			case (ogru_pkg::cfg_reg_t'(cfg_index))
				ogru_pkg::REG_LOG_FLOOR:    log_floor_q    <= cfg_data;
				ogru_pkg::REG_LOG_CEILING:  log_ceiling_q  <= cfg_data[14:0];
				ogru_pkg::REG_FREE_STEP:    free_step_q    <= cfg_data;
				ogru_pkg::REG_HIT_STEP:     hit_step_q     <= cfg_data[14:0];
				ogru_pkg::REG_DECAY_FACTOR: decay_factor_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			ogru_pkg::ST_IDLE: begin
				if (cmd_valid) begin
					tcol_q    <= target_col;
					trow_q    <= target_row;
					mark_q    <= mark_hit;
					count_q   <= '0;
					res_val_q <= '0;
				end
			end
			ogru_pkg::ST_RAY_INIT: begin
				pos_c_q <= ORIGIN;
				pos_r_q <= ORIGIN;
				dc_q    <= (end_c > ORIGIN) ? end_c - ORIGIN : ORIGIN - end_c;
				dr_q    <= (end_r > ORIGIN) ? end_r - ORIGIN : ORIGIN - end_r;
				sc_q    <= ORIGIN < end_c;
				sr_q    <= ORIGIN < end_r;
				err_q   <= ERR_W'((end_c > ORIGIN) ? end_c - ORIGIN : ORIGIN - end_c)
				         - ERR_W'((end_r > ORIGIN) ? end_r - ORIGIN : ORIGIN - end_r);
			end
			ogru_pkg::ST_RAY_VISIT: begin
				if (upd) begin
					last_q  <= at_end;
					delta_q <= at_end ? $signed({2'b00, hit_step_q})
					                  : ogru_pkg::STEP_W'(free_step_q);
				end
			end
			ogru_pkg::ST_RAY_SUM: begin
				sum_q <= SUM_W'($signed(rdata_q)) + SUM_W'(delta_q);
			end
			ogru_pkg::ST_RAY_WR: begin
				if (count_q != CNT_SAT) count_q <= count_q + CNT_W'(1);
			end
			ogru_pkg::ST_DEC_ABS: begin
				dneg_q <= rdata_q[CELL_BITS-1];
				dabs_q <= rdata_q[CELL_BITS-1] ? -rdata_q : rdata_q;
			end
			ogru_pkg::ST_DEC_MUL: begin
				prod_q <= PROD_W'(dabs_q) * PROD_W'(decay_factor_q);
			end
			ogru_pkg::ST_RD_WAIT: begin
				res_val_q <= rd_ext[VAL_W-1:0];
			end
			default: ;
		endcase
		if (adv) begin
			err_q <= err_next;
			if (step_c) pos_c_q <= sc_q ? pos_c_q + POS_W'(1) : pos_c_q - POS_W'(1);
			if (step_r) pos_r_q <= sr_q ? pos_r_q + POS_W'(1) : pos_r_q - POS_W'(1);
		end
		if (load_rsp) begin
			cell_value_q    <= res_val_q;
			cells_touched_q <= count_q;
		end
	end

	// grid memory
	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_addr] <= mem_wdata;
		if (mem_re) rdata_q <= mem[mem_addr];
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (load_rsp) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	assign cmd_ready     = cmd_ready_c;
	assign rsp_valid     = rsp_valid_q;
	assign cell_value    = cell_value_q;
	assign cells_touched = cells_touched_q;

endmodule

// ----- hw/rtl/ogru_checker.sv -----
// ----------------------------------------------------------------------------
// ogru_checker
// Port-level checks of the occupancy grid ray update block, bound to the top.
// ----------------------------------------------------------------------------
module ogru_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              cmd_valid,
	input logic                              cmd_ready,
	input logic                              rsp_valid,
	input logic                              rsp_ready,
	input logic signed [ogru_pkg::VAL_W-1:0] cell_value,
	input logic [ogru_pkg::CNT_W-1:0]        cells_touched
);

	// a stalled result beat stays up
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("rsp_valid dropped while stalled");

	// a stalled result beat keeps its payload
	a_rsp_stable: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> $stable(cell_value) && $stable(cells_touched))
		else $error("rsp payload changed while stalled");

	// only a ray touches cells, and a ray returns no cell value
	a_rsp_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && cells_touched != '0 |-> cell_value == '0)
		else $error("rsp carries both a cell value and a touch count");

	// an accepted command leaves cmd_ready low while the block works on it
	a_busy_after_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready |=> !cmd_ready)
		else $error("cmd_ready held across an accepted command");

endmodule

bind occupancy_grid_ray_update ogru_checker u_ogru_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.cmd_valid     (cmd_valid),
	.cmd_ready     (cmd_ready),
	.rsp_valid     (rsp_valid),
	.rsp_ready     (rsp_ready),
	.cell_value    (cell_value),
	.cells_touched (cells_touched)
);

// ----- verif/occupancy_grid_ray_update_test.sv -----
// ----------------------------------------------------------------------------
// occupancy_grid_ray_update_test
// Self-checking bench for the log-odds grid. It drives ray, decay, read and
// spare commands through the cmd channel and keeps its own copy of the grid
// and of the registers. Each rsp beat is compared in order against what that
// copy predicts. The run steps through several register settings, extremes
// included, and through four pacing modes of the two handshakes.
// ----------------------------------------------------------------------------
module occupancy_grid_ray_update_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SIDE            = ogru_pkg::GRID_SIDE_DEF;
	localparam int ORIGIN          = ogru_pkg::ORIGIN_CELL_DEF;
	localparam int CELLS           = SIDE * SIDE;
	localparam int VAL_W           = ogru_pkg::VAL_W;
	localparam int CNT_W           = ogru_pkg::CNT_W;
	localparam int CFG_W           = ogru_pkg::CFG_W;
	localparam int CFG_IDX_W       = ogru_pkg::CFG_IDX_W;
	localparam int COORD_W         = ogru_pkg::COORD_IN_W;
	localparam int WATCHDOG_LIMIT  = 1000000;	// a decay sweep passes with no beat on cmd or rsp
	localparam int ITEMS_PER_PHASE = 120;
	localparam int SETTLE_CYCLES   = 16;
	localparam logic [CFG_IDX_W-1:0] FIRST_SPARE_REG = 3'd5;
	localparam logic [COORD_W-1:0]   ORIGIN_C  = COORD_W'(ORIGIN);
	localparam logic [COORD_W-1:0]   EDGE_LO   = 8'd0;
	localparam logic [COORD_W-1:0]   EDGE_HI   = 8'd255;
	localparam logic [COORD_W-1:0]   INNER_C   = 8'd64;
	localparam logic [COORD_W-1:0]   ODD_COL   = 8'd200;
	localparam logic [COORD_W-1:0]   ODD_ROW   = 8'd37;

	typedef struct packed {
		logic signed [VAL_W-1:0] value;
		logic [CNT_W-1:0]        touched;
	} grid_result_t;

	class grid_tracker;
		int cells [CELLS];
		int floor_v, ceil_v, free_v, hit_v, decay_v;
		grid_result_t pending_results [$];
		int ray_path [$];
		int mismatches, checked, rays, reads, decays, spares;

		function new();
			foreach (cells[i])
				cells[i] = 0;
			floor_v = int'($signed(ogru_pkg::LOG_FLOOR_RST));
			ceil_v  = int'(ogru_pkg::LOG_CEILING_RST);
			free_v  = int'($signed(ogru_pkg::FREE_STEP_RST));
			hit_v   = int'(ogru_pkg::HIT_STEP_RST);
			decay_v = int'(ogru_pkg::DECAY_FACTOR_RST);
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
			case (idx)
				ogru_pkg::REG_LOG_FLOOR:    floor_v = int'($signed(data));
				ogru_pkg::REG_LOG_CEILING:  ceil_v  = int'(data[14:0]);
				ogru_pkg::REG_FREE_STEP:    free_v  = int'($signed(data));
				ogru_pkg::REG_HIT_STEP:     hit_v   = int'(data[14:0]);
				ogru_pkg::REG_DECAY_FACTOR: decay_v = int'(data);
				default: ;
			endcase
		endfunction

		// floor first, then ceiling: ceiling wins when they cross
		function void bump(int col, int row, int delta);
			int idx, sum;
			idx = row * SIDE + col;
			sum = cells[idx] + delta;
			if (sum < floor_v)
				sum = floor_v;
			if (sum > ceil_v)
				sum = ceil_v;
			cells[idx] = sum;
			ray_path.push_back(idx);
		endfunction

		function int trace_ray(int col, int row, bit mark);
			int dc, dr, sc, sr, err, e2, c, r, count;
			dc = col > ORIGIN ? col - ORIGIN : ORIGIN - col;
			dr = row > ORIGIN ? row - ORIGIN : ORIGIN - row;
			sc = ORIGIN < col ? 1 : -1;
			sr = ORIGIN < row ? 1 : -1;
			err = dc - dr;
			c = ORIGIN;
			r = ORIGIN;
			count = 0;
			ray_path.delete();
			while (c != col || r != row) begin
				if (c != ORIGIN || r != ORIGIN) begin
					bump(c, r, free_v);
					count++;
				end
				e2 = 2 * err;
				if (e2 > -dr) begin
					err -= dr;
					c += sc;
				end
				if (e2 < dc) begin
					err += dc;
					r += sr;
				end
			end
			if (mark) begin
				bump(c, r, hit_v);
				count++;
			end
			return count > 511 ? 511 : count;
		endfunction

		// magnitude times factor, truncated toward zero
		function void decay_grid();
			longint mag;
			int q;
			foreach (cells[i]) begin
				mag = longint'(cells[i] < 0 ? -cells[i] : cells[i]);
				mag = mag * longint'(decay_v);
				q = int'(mag >> 16);
				cells[i] = cells[i] < 0 ? -q : q;
			end
		endfunction

		function void note_cmd(ogru_pkg::cmd_t cmd, int col, int row, bit mark);
			grid_result_t res;
			res = '0;
			case (cmd)
				ogru_pkg::CMD_DECAY: begin
					decay_grid();
					decays++;
				end
				ogru_pkg::CMD_RAY: begin
					res.touched = CNT_W'(trace_ray(col, row, mark));
					rays++;
				end
				ogru_pkg::CMD_READ: begin
					res.value = VAL_W'(cells[row * SIDE + col]);
					reads++;
				end
				default: spares++;
			endcase
			pending_results.push_back(res);
		endfunction

		task report_mismatch(string what);
			mismatches++;
			$display("[%0t] mismatch: %s", $time, what);
		endtask

		task check_result(logic signed [VAL_W-1:0] value, logic [CNT_W-1:0] touched);
			grid_result_t exp_r;
			if (pending_results.size() == 0) begin
				report_mismatch($sformatf("rsp beat with nothing pending, value %0d touched %0d",
					value, touched));
			end else begin
				exp_r = pending_results.pop_front();
				checked++;
				if (value !== exp_r.value)
					report_mismatch($sformatf("cell_value %0d, predicted %0d",
						value, exp_r.value));
				if (touched !== exp_r.touched)
					report_mismatch($sformatf("cells_touched %0d, predicted %0d",
						touched, exp_r.touched));
			end
		endtask
	endclass

	logic clk;
	logic arst_n = 1'b0;
	logic cmd_valid = 1'b0;
	logic cmd_ready;
	logic [1:0] command = ogru_pkg::CMD_NONE;
	logic [COORD_W-1:0] target_col = '0;
	logic [COORD_W-1:0] target_row = '0;
	logic mark_hit = 1'b0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	logic signed [VAL_W-1:0] cell_value;
	logic [CNT_W-1:0] cells_touched;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0] cfg_data = '0;

	grid_tracker grid = new();
	int cmd_idle_pct = 0;
	int rsp_stall_pct = 0;
	int reg_writes = 0;
	int quiet_cycles = 0;

	occupancy_grid_ray_update u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd_valid     (cmd_valid),
		.cmd_ready     (cmd_ready),
		.command       (command),
		.target_col    (target_col),
		.target_row    (target_row),
		.mark_hit      (mark_hit),
		.rsp_valid     (rsp_valid),
		.rsp_ready     (rsp_ready),
		.cell_value    (cell_value),
		.cells_touched (cells_touched),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	always @(posedge clk) begin
		if (arst_n && rsp_valid && rsp_ready)
			grid.check_result(cell_value, cells_touched);
		rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
	end

	always @(posedge clk) begin
		if ((cmd_valid && cmd_ready) || (rsp_valid && rsp_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no beat on cmd or rsp for %0d cycles", quiet_cycles);
			$display("TB_ERROR");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic send_cmd(ogru_pkg::cmd_t cmd, logic [COORD_W-1:0] col,
		logic [COORD_W-1:0] row, logic mark);
		while ($urandom_range(99) < cmd_idle_pct) begin
			cmd_valid <= 1'b0;
			@(posedge clk);
		end
		cmd_valid  <= 1'b1;
		command    <= cmd;
		target_col <= col;
		target_row <= row;
		mark_hit   <= mark;
		do
			@(posedge clk);
		while (!cmd_ready);
		grid.note_cmd(cmd, col, row, mark);
	endtask

	task automatic drain();
		cmd_valid <= 1'b0;
		while (grid.pending_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		grid.set_reg(idx, data);
		reg_writes++;
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic setup_phase(int phase);
		case (phase)
			0: begin
				write_reg(ogru_pkg::REG_LOG_FLOOR, 16'h8000);
				write_reg(ogru_pkg::REG_LOG_CEILING, 16'hFFFF);	// top bit is not part of the register
				write_reg(ogru_pkg::REG_FREE_STEP, 16'h8000);
				write_reg(ogru_pkg::REG_HIT_STEP, 16'hFFFF);
				write_reg(ogru_pkg::REG_DECAY_FACTOR, 16'hFFFF);
			end
			1: begin
				write_reg(ogru_pkg::REG_LOG_FLOOR, CFG_W'($urandom));
				write_reg(ogru_pkg::REG_LOG_CEILING, CFG_W'($urandom));
				write_reg(ogru_pkg::REG_FREE_STEP, CFG_W'($urandom));
				write_reg(ogru_pkg::REG_HIT_STEP, CFG_W'($urandom));
				write_reg(ogru_pkg::REG_DECAY_FACTOR, CFG_W'($urandom));
			end
			2: begin
				// floor above ceiling, non-negative free step
				write_reg(ogru_pkg::REG_LOG_FLOOR, CFG_W'($urandom_range(32767, 300)));
				write_reg(ogru_pkg::REG_LOG_CEILING, CFG_W'($urandom_range(200, 0)));
				write_reg(ogru_pkg::REG_FREE_STEP, CFG_W'($urandom_range(500, 0)));
				write_reg(ogru_pkg::REG_HIT_STEP, '0);
				write_reg(ogru_pkg::REG_DECAY_FACTOR, '0);
			end
			default: begin
				write_reg(ogru_pkg::REG_LOG_FLOOR, CFG_W'(-$urandom_range(1280, 1)));
				write_reg(ogru_pkg::REG_LOG_CEILING, CFG_W'($urandom_range(2000, 1)));
				write_reg(ogru_pkg::REG_FREE_STEP, CFG_W'(-$urandom_range(300, 1)));
				write_reg(ogru_pkg::REG_HIT_STEP, CFG_W'($urandom_range(600, 1)));
				write_reg(ogru_pkg::REG_DECAY_FACTOR, CFG_W'($urandom));
			end
		endcase
		write_reg(FIRST_SPARE_REG + CFG_IDX_W'(phase % 3), CFG_W'($urandom));
	endtask

	task automatic directed_items();
		send_cmd(ogru_pkg::CMD_READ, EDGE_LO, EDGE_LO, 1'b0);
		send_cmd(ogru_pkg::CMD_READ, EDGE_HI, EDGE_HI, 1'b1);
		send_cmd(ogru_pkg::CMD_RAY, ORIGIN_C, ORIGIN_C, 1'b1);
		send_cmd(ogru_pkg::CMD_RAY, ORIGIN_C, ORIGIN_C, 1'b0);
		send_cmd(ogru_pkg::CMD_READ, ORIGIN_C, ORIGIN_C, 1'b0);
		send_cmd(ogru_pkg::CMD_RAY, EDGE_LO, EDGE_LO, 1'b1);
		send_cmd(ogru_pkg::CMD_RAY, EDGE_HI, EDGE_HI, 1'b0);
		send_cmd(ogru_pkg::CMD_RAY, EDGE_LO, EDGE_HI, 1'b1);
		send_cmd(ogru_pkg::CMD_RAY, EDGE_HI, EDGE_LO, 1'b1);
		send_cmd(ogru_pkg::CMD_RAY, EDGE_HI, ORIGIN_C, 1'b1);
		send_cmd(ogru_pkg::CMD_RAY, ORIGIN_C, EDGE_LO, 1'b0);
		send_cmd(ogru_pkg::CMD_RAY, ODD_COL, ODD_ROW, 1'b1);
		send_cmd(ogru_pkg::CMD_NONE, 8'hA5, 8'h5A, 1'b1);
		send_cmd(ogru_pkg::CMD_READ, EDGE_LO, EDGE_LO, 1'b0);
		send_cmd(ogru_pkg::CMD_READ, INNER_C, INNER_C, 1'b0);
		send_cmd(ogru_pkg::CMD_READ, EDGE_HI, ORIGIN_C, 1'b0);
		send_cmd(ogru_pkg::CMD_READ, ODD_COL, ODD_ROW, 1'b0);
		send_cmd(ogru_pkg::CMD_DECAY, EDGE_LO, EDGE_LO, 1'b0);
		send_cmd(ogru_pkg::CMD_READ, EDGE_LO, EDGE_LO, 1'b0);
		send_cmd(ogru_pkg::CMD_READ, INNER_C, INNER_C, 1'b0);
		send_cmd(ogru_pkg::CMD_READ, ORIGIN_C, ORIGIN_C, 1'b0);
		send_cmd(ogru_pkg::CMD_READ, ODD_COL, ODD_ROW, 1'b0);
	endtask

	// half the rays hit a small set of endpoints so cells saturate; most reads follow
	// the last ray's path so they land on written cells
	task automatic random_items(int count, bit with_decay);
		logic [COORD_W-1:0] pool_col [8];
		logic [COORD_W-1:0] pool_row [8];
		logic [COORD_W-1:0] col, row;
		int roll, pick, idx;
		for (int k = 0; k < 8; k++) begin
			pool_col[k] = k[0] ? 8'hFF : (k < 4 ? 8'h00 : COORD_W'($urandom));
			pool_row[k] = k[1] ? 8'hFF : (k < 4 ? 8'h00 : COORD_W'($urandom));
		end
		for (int i = 0; i < count; i++) begin
			if (with_decay && i == count / 2)
				send_cmd(ogru_pkg::CMD_DECAY, COORD_W'($urandom), COORD_W'($urandom),
					1'($urandom));
			roll = $urandom_range(99);
			col = COORD_W'($urandom);
			row = COORD_W'($urandom);
			if (roll < 55) begin
				if ($urandom_range(1)) begin
					pick = $urandom_range(7);
					col = pool_col[pick];
					row = pool_row[pick];
				end
				send_cmd(ogru_pkg::CMD_RAY, col, row, 1'($urandom));
			end else if (roll < 95) begin
				if (grid.ray_path.size() != 0 && $urandom_range(99) < 70) begin
					idx = grid.ray_path[$urandom_range(grid.ray_path.size() - 1)];
					col = COORD_W'(idx % SIDE);
					row = COORD_W'(idx / SIDE);
				end
				send_cmd(ogru_pkg::CMD_READ, col, row, 1'($urandom));
			end else begin
				send_cmd(ogru_pkg::CMD_NONE, col, row, 1'($urandom));
			end
		end
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		directed_items();
		drain();
		for (int p = 0; p < 4; p++) begin
			setup_phase(p);
			case (p)
				0: begin
					cmd_idle_pct = 0;
					rsp_stall_pct = 0;
				end
				1: begin
					cmd_idle_pct = 47;
					rsp_stall_pct = 0;
				end
				2: begin
					cmd_idle_pct = 0;
					rsp_stall_pct = 47;
				end
				default: begin
					cmd_idle_pct = 11;
					rsp_stall_pct = 11;
				end
			endcase
			random_items(ITEMS_PER_PHASE, p == 0);
			drain();
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("Commands: %0d rays, %0d reads, %0d decays, %0d spare, under four pacing modes",
			grid.rays, grid.reads, grid.decays, grid.spares);
		$display("Checked %0d result beats after %0d register writes; %0d mismatches",
			grid.checked, reg_writes, grid.mismatches);
		if (grid.mismatches == 0 && grid.pending_results.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

// ----- occupancy_grid_ray_update.f -----
hw/rtl/ogru_pkg.sv
hw/rtl/occupancy_grid_ray_update.sv
hw/rtl/ogru_checker.sv
verif/occupancy_grid_ray_update_test.sv
